// File: rtl/wssl_pkg.sv
// Types and constants shared by the weekly setpoint schedule lookup block.
`default_nettype none
package wssl_pkg;

   localparam int DAYS    = 7;
   localparam int DAY_W   = 3;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 4;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int TEMP_W  = 8;
   localparam int KEY_W   = HOUR_W + MIN_W;
   localparam int ENTRY_W = KEY_W + TEMP_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_DEFAULT_SETPOINT = 1'b0;
   localparam logic [TEMP_W-1:0] DEFAULT_SETPOINT_RESET = 8'd20;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_COUNT = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   localparam logic [1:0] SRC_SAME    = 2'd0;
   localparam logic [1:0] SRC_EARLIER = 2'd1;
   localparam logic [1:0] SRC_WRAP    = 2'd2;
   localparam logic [1:0] SRC_DEFAULT = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [DAY_W-1:0]   day;
      logic [SLOT_W-1:0]  slot;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [TEMP_W-1:0]  temperature;
      logic [COUNT_W-1:0] entry_count;
   } req_beat_type;

   typedef struct packed {
      logic [TEMP_W-1:0] setpoint;
      logic [1:0]        source;
      logic              error;
   } rsp_beat_type;

   typedef struct packed {
      logic              accept;
      logic              clear_best;
      logic              issue;
      logic              same_day;
      logic              finish;
      logic [DAY_W-1:0]  day;
      logic [SLOT_W-1:0] slot;
      logic [1:0]        source;
   } cmd_type;

   typedef struct packed {
      logic               scan_start;
      logic [DAY_W-1:0]   new_day;
      logic [DAY_W-1:0]   q_day;
      logic [COUNT_W-1:0] day_count;
      logic               best_valid;
      logic               out_free;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/weekly_setpoint_schedule_lookup_core.sv
// Top level of the weekly setpoint schedule store and lookup.
//
//  channel | direction | handshake            | beat
//  req     | in        | req_valid/req_stall  | req_beat_type: request, day, slot, time, temp
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_beat_type: setpoint, source, error
//  csr     | in/out    | APB, pready always 1 | default_setpoint at addresses 0 to 3
//
// Writes, count updates and refused requests answer in the cycle after the beat.
// A query walks up to DAYS+1 days through the single entry memory read port,
// each day through ST_DAY, then ST_SCAN per entry and ST_DRAIN if it has any,
// then ST_CHECK; the answer loads in ST_FINISH. Reset is synchronous and
// clears the day counts; the entry memory is not cleared. A result held by
// rsp_stall stays in the output register and keeps req_stall high until it is taken.
`default_nettype none
module weekly_setpoint_schedule_lookup_core #(
   parameter int ENTRIES_PER_DAY = 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wssl_pkg::req_beat_type               req_beat,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output wssl_pkg::rsp_beat_type               rsp_beat,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire [wssl_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire [wssl_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [wssl_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import wssl_pkg::*;

   logic [TEMP_W-1:0] default_ff, default_in;
   logic              csr_hit;
   cmd_type           cmd;
   status_type        sts;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1] == REG_DEFAULT_SETPOINT;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(default_ff) : '0;

   always_comb begin
      default_in = default_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         default_in = csr_pwdata[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff <= DEFAULT_SETPOINT_RESET;
      end else begin
         default_ff <= default_in;
      end
   end

   wssl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wssl_dpath #(
      .ENTRIES_PER_DAY (ENTRIES_PER_DAY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_beat         (req_beat),
      .default_setpoint (default_ff),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_beat         (rsp_beat)
   );

endmodule
`default_nettype wire

// File: rtl/wssl_ctrl.sv
// Query sequencer: walks days and slots and tells the datapath what to read.
`default_nettype none
module wssl_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wssl_pkg::status_type sts,
   output wssl_pkg::cmd_type   cmd
);
   import wssl_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DAY    = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam logic [DAY_W-1:0] LAST_DAY = DAY_W'(DAYS);

   logic [2:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [DAY_W-1:0]  day_ff, day_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              accept;

   assign req_stall = !((state_ff == ST_IDLE) && sts.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      day_in   = day_ff;
      slot_in  = slot_ff;
      cmd            = '0;
      cmd.accept     = accept;
      cmd.day        = day_ff;
      cmd.slot       = slot_ff;
      cmd.source     = phase_ff;
      cmd.same_day   = (phase_ff == SRC_SAME);
      case (state_ff)
         ST_IDLE: begin
            if (accept && sts.scan_start) begin
               phase_in = SRC_SAME;
               day_in   = sts.new_day;
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            cmd.clear_best = 1'b1;
            slot_in        = '0;
            if (sts.day_count == '0) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (COUNT_W'(slot_ff + SLOT_W'(1)) == sts.day_count) begin
               state_in = ST_DRAIN;
            end else begin
               slot_in = SLOT_W'(slot_ff + SLOT_W'(1));
            end
         end
         ST_DRAIN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.best_valid) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DAY;
               case (phase_ff)
                  SRC_SAME: begin
                     if (sts.q_day > DAY_W'(1)) begin
                        phase_in = SRC_EARLIER;
                        day_in   = DAY_W'(sts.q_day - DAY_W'(1));
                     end else begin
                        phase_in = SRC_WRAP;
                        day_in   = LAST_DAY;
                     end
                  end
                  SRC_EARLIER: begin
                     if (day_ff > DAY_W'(1)) begin
                        day_in = DAY_W'(day_ff - DAY_W'(1));
                     end else begin
                        phase_in = SRC_WRAP;
                        day_in   = LAST_DAY;
                     end
                  end
                  default: begin
                     if (day_ff > sts.q_day) begin
                        day_in = DAY_W'(day_ff - DAY_W'(1));
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
               endcase
            end
         end
         ST_FINISH: begin
            cmd.finish = sts.out_free;
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= SRC_SAME;
         day_ff   <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         day_ff   <= day_in;
         slot_ff  <= slot_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/wssl_dpath.sv
// Datapath: entry memory, day counts, latest-time compare and result register.
`default_nettype none
module wssl_dpath #(
   parameter int ENTRIES_PER_DAY = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wssl_pkg::req_beat_type             req_beat,
   input  wire [wssl_pkg::TEMP_W-1:0]         default_setpoint,
   input  wssl_pkg::cmd_type                  cmd,
   output wssl_pkg::status_type               sts,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output wssl_pkg::rsp_beat_type             rsp_beat
);
   import wssl_pkg::*;

   localparam int DEPTH  = DAYS * ENTRIES_PER_DAY;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [SLOT_W-1:0]  SLOT_LIMIT  = SLOT_W'(ENTRIES_PER_DAY);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(ENTRIES_PER_DAY);
   localparam logic [DAY_W-1:0]   LAST_DAY    = DAY_W'(DAYS);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [COUNT_W-1:0] day_counts_ff [DAYS];

   logic [ENTRY_W-1:0] rdata_ff;
   logic               cmp_valid_ff;
   logic               best_valid_ff, best_valid_in;
   logic [KEY_W-1:0]   best_key_ff, best_key_in;
   logic [TEMP_W-1:0]  best_temp_ff, best_temp_in;
   logic [KEY_W-1:0]   q_key_ff;
   logic [DAY_W-1:0]   q_day_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_ff, rsp_in;

   logic               day_ok, slot_ok, count_ok, do_write, do_count, scan_start;
   logic [DAY_W-1:0]   req_day0, cmd_day0;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [KEY_W-1:0]   key;
   logic               qualify, update, out_free, load_now;

   assign day_ok     = (req_beat.day != '0) && (req_beat.day <= LAST_DAY);
   assign slot_ok    = req_beat.slot < SLOT_LIMIT;
   assign count_ok   = req_beat.entry_count <= COUNT_LIMIT;
   assign scan_start = (req_beat.req_type == REQ_QUERY) && day_ok;
   assign do_write   = cmd.accept && (req_beat.req_type == REQ_WRITE) && day_ok && slot_ok;
   assign do_count   = cmd.accept && (req_beat.req_type == REQ_COUNT) && day_ok && count_ok;
   assign req_day0   = DAY_W'(req_beat.day - DAY_W'(1));
   assign cmd_day0   = DAY_W'(cmd.day - DAY_W'(1));
   assign wr_addr    = ADDR_W'(ADDR_W'(req_day0) * ADDR_W'(ENTRIES_PER_DAY)
                               + ADDR_W'(req_beat.slot));
   assign rd_addr    = ADDR_W'(ADDR_W'(cmd_day0) * ADDR_W'(ENTRIES_PER_DAY)
                               + ADDR_W'(cmd.slot));

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_addr] <= {req_beat.hour, req_beat.minute, req_beat.temperature};
      end
      if (cmd.issue) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DAYS; i++) begin
            day_counts_ff[i] <= '0;
         end
      end else if (do_count) begin
         day_counts_ff[req_day0] <= req_beat.entry_count;
      end
   end

   // latest time, at or before the limit on the query's own day; strict compare keeps the lower slot
   assign key     = rdata_ff[ENTRY_W-1:TEMP_W];
   assign qualify = !cmd.same_day || (key <= q_key_ff);
   assign update  = cmp_valid_ff && qualify && (!best_valid_ff || (key > best_key_ff));

   always_comb begin
      best_valid_in = best_valid_ff;
      best_key_in   = best_key_ff;
      best_temp_in  = best_temp_ff;
      if (cmd.clear_best) begin
         best_valid_in = 1'b0;
      end else if (update) begin
         best_valid_in = 1'b1;
         best_key_in   = key;
         best_temp_in  = rdata_ff[TEMP_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_now = cmd.accept && !scan_start;

   always_comb begin
      rsp_in = '0;
      if (cmd.finish) begin
         rsp_in.setpoint = best_valid_ff ? best_temp_ff : default_setpoint;
         rsp_in.source   = best_valid_ff ? cmd.source : SRC_DEFAULT;
      end else begin
         case (req_beat.req_type)
            REQ_WRITE: begin
               rsp_in.error = !(day_ok && slot_ok);
            end
            REQ_COUNT: begin
               rsp_in.error = !(day_ok && count_ok);
            end
            REQ_QUERY: begin
               rsp_in.setpoint = default_setpoint;
               rsp_in.source   = SRC_DEFAULT;
               rsp_in.error    = 1'b1;
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_now || cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cmp_valid_ff  <= cmd.issue;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_key_ff  <= best_key_in;
      best_temp_ff <= best_temp_in;
      if (cmd.accept) begin
         q_key_ff <= {req_beat.hour, req_beat.minute};
         q_day_ff <= req_beat.day;
      end
      if (load_now || cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.scan_start = scan_start;
   assign sts.new_day    = req_beat.day;
   assign sts.q_day      = q_day_ff;
   assign sts.day_count  = day_counts_ff[cmd_day0];
   assign sts.best_valid = best_valid_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/wssl_checker.sv
// Port-level checks for the schedule lookup core, bound to the top level.
`default_nettype none
module wssl_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input wssl_pkg::req_beat_type req_beat,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input wssl_pkg::rsp_beat_type rsp_beat
);
   import wssl_pkg::*;

   logic req_take;

   assign req_take = req_valid && !req_stall;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
      else $error("stalled result beat changed");

   a_plain_req_answers: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_beat.req_type != REQ_QUERY) |=> rsp_valid)
      else $error("non-query beat not answered next cycle");

   a_bad_day_query: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_beat.req_type == REQ_QUERY) && (req_beat.day == '0)
      |=> rsp_valid && rsp_beat.error && (rsp_beat.source == SRC_DEFAULT))
      else $error("query on day zero not refused with default");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_beat.req_type == REQ_QUERY) && (req_beat.day != '0)
      |=> req_stall)
      else $error("request taken while a query scan starts");

endmodule

bind weekly_setpoint_schedule_lookup_core wssl_checker u_wssl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_beat  (req_beat),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_beat  (rsp_beat)
);
`default_nettype wire
